// ===== rtl/sct_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sct_pkg: shared types and constants for the Taylor-series sine/cosine block
// Holds the fixed-point widths, selector codes, divisor tables and the
// record that travels through the chain of series cells.
// ============================================================================
package sct_pkg;

  localparam int unsigned Terms    = 10;
  localparam int unsigned FracBits = 28;
  localparam int unsigned AngW     = 31;
  localparam int unsigned MagW     = FracBits + 3;
  localparam int unsigned X2W      = FracBits + 5;
  localparam int unsigned TermW    = FracBits + 4;
  localparam int unsigned SumW     = FracBits + 6;
  localparam int unsigned DivSteps = 2 * FracBits + 5;

  // The magnitude is clamped to 4.0, so a rescaled term product stays below
  // 2^(FracBits+8). It is split in two halves for the reciprocal divide.
  localparam int unsigned ProdW    = FracBits + 8;
  localparam int unsigned HalfW    = ProdW / 2;
  localparam int unsigned OddW     = 8;
  localparam int unsigned RecShift = HalfW + 2 * OddW;
  localparam int unsigned RecW     = RecShift + 1;

  typedef enum logic [1:0] {
    FuncSin = 2'd0,
    FuncCos = 2'd1,
    FuncTan = 2'd2,
    FuncNop = 2'd3
  } func_e;

  // Request flowing through the series cells: sine and cosine run side by side.
  typedef struct packed {
    logic               vld;
    func_e              func;
    logic               neg;
    logic [X2W-1:0]     x2;
    logic [TermW-1:0]   st;
    logic [TermW-1:0]   ct;
    logic signed [SumW-1:0] ssum;
    logic signed [SumW-1:0] csum;
  } cell_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] value;
    logic        sat;
  } res_t;

  // Divisor n*(n-1) written as odd * 2^sh, with half the divisor for rounding
  // and the reciprocal of the odd part scaled by 2^RecShift (rounded up).
  typedef struct packed {
    logic [2:0]      sh;
    logic [OddW-1:0] half;
    logic [OddW-1:0] odd;
    logic [RecW-1:0] rec;
  } dinfo_t;

  typedef dinfo_t [Terms-1:0] dtab_t;

  function automatic dtab_t build_dtab(input int unsigned n0);
    dtab_t       tab;
    int unsigned n;
    int unsigned d;
    int unsigned o;
    int unsigned s;
    tab = '0;
    for (int unsigned k = 1; k < Terms; k++) begin
      n = n0 + 2 * k;
      d = n * (n - 1);
      o = d;
      s = 0;
      while (o[0] == 1'b0) begin
        o = o >> 1;
        s = s + 1;
      end
      tab[k].sh   = 3'(s);
      tab[k].half = OddW'(d >> 1);
      tab[k].odd  = OddW'(o);
      tab[k].rec  = RecW'(((64'd1 << RecShift) + 64'(o) - 64'd1) / 64'(o));
    end
    return tab;
  endfunction

  localparam dtab_t SinDiv = build_dtab(1);
  localparam dtab_t CosDiv = build_dtab(0);

endpackage

// ===== rtl/sct_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sct_in_if / sct_out_if: valid/ready channels of the sine/cosine block
// One interface for the angle request and one for the result.
// ============================================================================
interface sct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic signed [30:0] angle;
  modport source (output valid, func, angle, input ready);
  modport sink (input valid, func, angle, output ready);
endinterface

interface sct_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  logic        saturated;
  modport source (output valid, value, saturated, input ready);
  modport sink (input valid, value, saturated, output ready);
endinterface

// ===== rtl/sct_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sct_cell: one term of the sine and cosine series
// Four internal stages: multiply by x^2, upper quotient half, lower quotient
// half, accumulate.
// ============================================================================
module sct_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [3:0]     k_i,
  input  sct_pkg::cell_t d_i,
  output sct_pkg::cell_t d_o
);
  import sct_pkg::*;

  localparam int unsigned MulW = TermW + X2W;
  localparam int unsigned HiW  = HalfW + RecW;
  localparam int unsigned LoW  = HalfW + OddW;
  localparam int unsigned LoMW = LoW + RecW;

  cell_t a_q, b_q, c_q, d_q;
  cell_t c_d, d_d;
  dinfo_t sdi, cdi;
  logic [MulW-1:0] sm, cm;
  logic [ProdW-1:0] sp_q, cp_q;
  logic [ProdW:0] sn, cn;
  logic [ProdW-1:0] ss, cs;
  logic [HiW-1:0] sqh, cqh;
  logic [HalfW-1:0] sqh_q, cqh_q, snh_q, cnh_q, snl_q, cnl_q;
  logic [HalfW-1:0] srh, crh;
  logic [LoMW-1:0] sql, cql;

  assign sdi = SinDiv[k_i];
  assign cdi = CosDiv[k_i];

  // Term times x^2, rescaled with rounding half up.
  always_comb begin
    sm = MulW'(d_i.st) * MulW'(d_i.x2) + (MulW'(1) << (FracBits-1));
    cm = MulW'(d_i.ct) * MulW'(d_i.x2) + (MulW'(1) << (FracBits-1));
  end

  // Add half the divisor and drop its power of two; the upper half of the
  // quotient by the odd part comes from a reciprocal multiplication.
  always_comb begin
    sn  = (ProdW+1)'(sp_q) + (ProdW+1)'(sdi.half);
    cn  = (ProdW+1)'(cp_q) + (ProdW+1)'(cdi.half);
    ss  = ProdW'(sn >> sdi.sh);
    cs  = ProdW'(cn >> cdi.sh);
    sqh = HiW'(ss[ProdW-1:HalfW]) * HiW'(sdi.rec);
    cqh = HiW'(cs[ProdW-1:HalfW]) * HiW'(cdi.rec);
  end

  // The remainder of the upper half, joined to the lower half, gives the
  // lower half of the quotient.
  always_comb begin
    srh    = snh_q - HalfW'(sqh_q * HalfW'(sdi.odd));
    crh    = cnh_q - HalfW'(cqh_q * HalfW'(cdi.odd));
    sql    = LoMW'({srh[OddW-1:0], snl_q}) * LoMW'(sdi.rec);
    cql    = LoMW'({crh[OddW-1:0], cnl_q}) * LoMW'(cdi.rec);
    c_d    = b_q;
    c_d.st = TermW'({sqh_q, sql[RecShift +: HalfW]});
    c_d.ct = TermW'({cqh_q, cql[RecShift +: HalfW]});
  end

  // Terms alternate in sign.
  always_comb begin
    d_d = c_q;
    if (k_i[0]) begin
      d_d.ssum = c_q.ssum - SumW'(c_q.st);
      d_d.csum = c_q.csum - SumW'(c_q.ct);
    end else begin
      d_d.ssum = c_q.ssum + SumW'(c_q.st);
      d_d.csum = c_q.csum + SumW'(c_q.ct);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q.vld <= 1'b0;
      b_q.vld <= 1'b0;
      c_q.vld <= 1'b0;
      d_q.vld <= 1'b0;
    end else if (en_i) begin
      a_q   <= d_i;
      sp_q  <= ProdW'(sm >> FracBits);
      cp_q  <= ProdW'(cm >> FracBits);
      b_q   <= a_q;
      sqh_q <= HalfW'(sqh >> RecShift);
      cqh_q <= HalfW'(cqh >> RecShift);
      snh_q <= ss[ProdW-1:HalfW];
      cnh_q <= cs[ProdW-1:HalfW];
      snl_q <= ss[HalfW-1:0];
      cnl_q <= cs[HalfW-1:0];
      c_q   <= c_d;
      d_q   <= d_d;
    end
  end

  assign d_o = d_q;
endmodule

// ===== rtl/sct_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sct_div: pipelined restoring divider and output formatting
// One quotient bit per stage; also clips tangent results and sets the flag.
// ============================================================================
module sct_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  sct_pkg::cell_t d_i,
  output sct_pkg::res_t  r_o
);
  import sct_pkg::*;

  localparam int unsigned NumW = SumW + FracBits + 1;

  typedef struct packed {
    logic vld;
    func_e func;
    logic sneg;
    logic qneg;
    logic czero;
    logic signed [SumW-1:0] sval;
    logic signed [SumW-1:0] cval;
    logic [NumW-1:0] num;
    logic [SumW-1:0] den;
    logic [NumW-1:0] rem;
    logic [NumW-1:0] quo;
  } dv_t;

  dv_t st_q [DivSteps+1];
  dv_t st_d [DivSteps+1];
  res_t r_q;

  logic signed [SumW-1:0] s0;
  logic [SumW-1:0] sm0, cm0;

  always_comb begin
    s0  = d_i.neg ? -d_i.ssum : d_i.ssum;
    sm0 = s0[SumW-1] ? SumW'(-s0) : SumW'(s0);
    cm0 = d_i.csum[SumW-1] ? SumW'(-d_i.csum) : SumW'(d_i.csum);
    st_d[0].vld   = d_i.vld;
    st_d[0].func  = d_i.func;
    st_d[0].sneg  = s0[SumW-1];
    st_d[0].qneg  = s0[SumW-1] ^ d_i.csum[SumW-1];
    st_d[0].czero = (cm0 == '0);
    st_d[0].sval  = s0;
    st_d[0].cval  = d_i.csum;
    st_d[0].num   = (NumW'(sm0) << FracBits) + NumW'(cm0 >> 1);
    st_d[0].den   = cm0;
    st_d[0].rem   = '0;
    st_d[0].quo   = '0;
  end

  for (genvar i = 1; i <= DivSteps; i++) begin : g_step
    logic [NumW:0] tr;
    always_comb begin
      st_d[i] = st_q[i-1];
      tr = {st_q[i-1].rem, st_q[i-1].num[DivSteps-i]};
      if (tr >= (NumW+1)'(st_q[i-1].den)) begin
        st_d[i].rem = NumW'(tr - (NumW+1)'(st_q[i-1].den));
        st_d[i].quo = {st_q[i-1].quo[NumW-2:0], 1'b1};
      end else begin
        st_d[i].rem = NumW'(tr);
        st_d[i].quo = {st_q[i-1].quo[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DivSteps; i++) st_q[i].vld <= 1'b0;
    end else if (en_i) begin
      st_q[0] <= st_d[0];
      for (int i = 1; i <= DivSteps; i++) st_q[i] <= st_d[i];
    end
  end

  // Final formatting; quotient bits above DivSteps are known zero.
  dv_t f;
  res_t r_d;
  logic [NumW-1:0] q;
  always_comb begin
    f = st_q[DivSteps];
    q = f.quo;
    r_d.vld = f.vld;
    r_d.sat = 1'b0;
    r_d.value = '0;
    case (f.func)
      FuncSin: r_d.value = 32'(f.sval);
      FuncCos: r_d.value = 32'(f.cval);
      FuncTan: begin
        if (f.czero) begin
          r_d.sat = 1'b1;
          r_d.value = f.sneg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (f.qneg) begin
          if (q > NumW'(33'h1_0000_0000 >> 1)) begin
            r_d.sat = 1'b1;
            r_d.value = 32'h8000_0000;
          end else begin
            r_d.value = 32'(-q);
          end
        end else if (q > NumW'(32'h7fff_ffff)) begin
          r_d.sat = 1'b1;
          r_d.value = 32'h7fff_ffff;
        end else begin
          r_d.value = 32'(q);
        end
      end
      default: r_d.value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_q.vld <= 1'b0;
    else if (en_i) r_q <= r_d;
  end
  assign r_o = r_q;
endmodule

// ===== rtl/sine_cosine_taylor_series.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sine_cosine_taylor_series: sine, cosine and tangent by Taylor series
// Fully pipelined chain of term cells followed by a pipelined divider.
// ============================================================================
// Channel | Direction | Payload
// in_if   | sink      | func, angle (Q2.28)
// out_if  | source    | value (Q3.28), saturated
//
// One request is accepted every cycle while the output can move. A request
// passes through the magnitude register, one stage for x^2, four per series
// cell over nine cells, and 63 in the divider (input register, one per
// quotient bit, output register).
// The whole pipeline advances together; it stalls only when the output
// register holds a result that has not been taken.
// Reset clears all valid bits asynchronously.
module sine_cosine_taylor_series (
  input logic clk_i,
  input logic rst_ni,
  sct_in_if.sink    in_if,
  sct_out_if.source out_if
);
  import sct_pkg::*;

  logic en;
  cell_t c0_q;
  cell_t ch [Terms];
  res_t res;
  logic [MagW-1:0] mag;
  logic [2*MagW-1:0] sq;
  logic [1:0] mq_func;
  logic mq_vld, mq_neg;
  logic [MagW-1:0] mq_mag;

  // Advance when the output slot is empty or being taken.
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // Magnitude of the angle, clamped to 4.0.
  always_comb begin
    mag = in_if.angle[AngW-1] ? MagW'(-in_if.angle) : MagW'(in_if.angle);
    if (mag > (MagW'(4) << FracBits)) mag = MagW'(4) << FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mq_vld <= 1'b0;
    else if (en) begin
      mq_vld  <= in_if.valid;
      mq_func <= in_if.func;
      mq_neg  <= in_if.angle[AngW-1];
      mq_mag  <= mag;
    end
  end

  // x^2 reaches 16.0 at the clamp, so it needs two more integer bits than
  // the magnitude.
  assign sq = mq_mag * mq_mag + ((2*MagW)'(1) << (FracBits-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c0_q.vld <= 1'b0;
    else if (en) begin
      c0_q.vld  <= mq_vld;
      c0_q.func <= func_e'(mq_func);
      c0_q.neg  <= mq_neg;
      c0_q.x2   <= X2W'(sq >> FracBits);
      c0_q.st   <= TermW'(mq_mag);
      c0_q.ct   <= TermW'(1) << FracBits;
      c0_q.ssum <= SumW'(mq_mag);
      c0_q.csum <= SumW'(1) << FracBits;
    end
  end

  assign ch[0] = c0_q;
  for (genvar k = 1; k < Terms; k++) begin : g_cell
    sct_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .k_i(4'(k)), .d_i(ch[k-1]), .d_o(ch[k])
    );
  end

  sct_div u_div (.clk_i, .rst_ni, .en_i(en), .d_i(ch[Terms-1]), .r_o(res));

  assign out_if.valid     = res.vld;
  assign out_if.value     = res.value;
  assign out_if.saturated = res.sat;

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.value))
    else $error("result changed while stalled");
  // A raised flag only ever comes with a value clipped to a range end.
  a_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.saturated |-> res.value == 32'h7fff_ffff
      || res.value == 32'h8000_0000)
    else $error("saturated flag with unclipped value");
endmodule
